// File: rtl/core/k_way_sorted_list_merge_defines.svh
// Assertion helpers for the k-way merge block.
`ifndef K_WAY_SORTED_LIST_MERGE_DEFINES_SVH
`define K_WAY_SORTED_LIST_MERGE_DEFINES_SVH

// Clocked, reset-qualified implication check.
`define KWM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Clocked, reset-qualified next-cycle implication check.
`define KWM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/kwm_pkg.sv
// ---------------------------------------------------------------------------
// kwm_pkg
// Shared constants, types and command/status structs of the k-way merge.
// ---------------------------------------------------------------------------
`default_nettype none
package kwm_pkg;
    localparam int NumLists    = 8;
    localparam int ListDepth   = 256;
    localparam int PayloadBits = 32;
    localparam int LW = (NumLists > 1) ? $clog2(NumLists) : 1;
    localparam int DW = (ListDepth > 1) ? $clog2(ListDepth) : 1;
    localparam int CW = $clog2(ListDepth + 1);
    localparam int AW = LW + DW;
    localparam logic [31:0] SentinelKey = 32'hffff_ffff;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] ST_PUSHED   = 3'd0;
    localparam logic [2:0] ST_POPPED   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_RESERVED = 3'd4;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture input item
        logic push;      // write item, advance tail
        logic pop;       // read head of winner, advance head
        logic clear;     // empty every list
        logic scan_go;   // start a head scan
        logic finish;    // form the result
    } kwm_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic       scan_busy;
        logic [1:0] cmd;
        logic       push_ok;
        logic       any_valid;
    } kwm_stat_t;
endpackage
`default_nettype wire

// File: rtl/core/k_way_sorted_list_merge.sv
// ---------------------------------------------------------------------------
// k_way_sorted_list_merge
// Merges eight ascending key/payload lists with push, pop and clear items.
// ---------------------------------------------------------------------------
// Channel  Direction  Ports
// s_       in         s_valid s_ready s_cmd s_list_id s_item_key s_item_payload
// m_       out        m_valid m_ready m_status m_popped_key m_popped_payload
//                     m_source_list m_next_key
//
// One item at a time. A push or clear runs the serial head scan that rebuilds
// next_key; a pop runs one scan to find the winner, a registered memory read,
// a head refresh of the popped list and a second scan (no refresh when the
// pop empties its list).
// Reset (aresetn low, synchronous) empties every list; memory is not cleared.
// A stalled result holds m_ valid and data; no new item is taken meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none
`include "k_way_sorted_list_merge_defines.svh"
module k_way_sorted_list_merge import kwm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [2:0]  s_list_id,
    input  wire logic [31:0] s_item_key,
    input  wire logic [31:0] s_item_payload,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_popped_key,
    output logic [31:0]      m_popped_payload,
    output logic [2:0]       m_source_list,
    output logic [31:0]      m_next_key
);
    kwm_cmd_t    cmd;
    kwm_stat_t   stat;
    logic [2:0]  r_status;
    logic [31:0] r_popped_key;
    logic [31:0] r_popped_payload;
    logic [2:0]  r_source_list;
    logic [31:0] best_key;

    // The datapath reports the key of the last scan's winner, which becomes
    // next_key once the final scan of an item is done.
    kwm_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_in           (cmd),
        .stat_out         (stat),
        .s_cmd            (s_cmd),
        .s_list_id        (s_list_id),
        .s_item_key       (s_item_key),
        .s_item_payload   (s_item_payload),
        .r_status         (r_status),
        .r_popped_key     (r_popped_key),
        .r_popped_payload (r_popped_payload),
        .r_source_list    (r_source_list),
        .best_key         (best_key)
    );

    kwm_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .cmd_out          (cmd),
        .stat_in          (stat),
        .r_status         (r_status),
        .r_popped_key     (r_popped_key),
        .r_popped_payload (r_popped_payload),
        .r_source_list    (r_source_list),
        .best_key         (best_key),
        .m_status         (m_status),
        .m_popped_key     (m_popped_key),
        .m_popped_payload (m_popped_payload),
        .m_source_list    (m_source_list),
        .m_next_key       (m_next_key)
    );

    // No item is taken while a result waits.
    `KWM_ASSERT_IMPL(a_no_take_while_full, aclk, aresetn, m_valid, !s_ready)
    // An empty-pop result never carries a source list.
    `KWM_ASSERT_IMPL(a_empty_src, aclk, aresetn, m_valid && (m_status == ST_EMPTY),
        m_source_list == 3'd0)
    // A popped item always carries a real key, never the sentinel.
    `KWM_ASSERT_IMPL(a_push_next, aclk, aresetn, m_valid && (m_status == ST_POPPED),
        m_popped_key != SentinelKey)
endmodule
`default_nettype wire

// File: rtl/core/kwm_datapath.sv
// ---------------------------------------------------------------------------
// kwm_datapath
// List memory, head/tail pointers, head-key cache and the serial winner scan.
// ---------------------------------------------------------------------------
`default_nettype none
module kwm_datapath import kwm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire kwm_cmd_t    cmd_in,
    output kwm_stat_t        stat_out,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [2:0]  s_list_id,
    input  wire logic [31:0] s_item_key,
    input  wire logic [31:0] s_item_payload,
    output logic [2:0]       r_status,
    output logic [31:0]      r_popped_key,
    output logic [31:0]      r_popped_payload,
    output logic [2:0]       r_source_list,
    output logic [31:0]      best_key
);
    logic [31+PayloadBits:0] mem [NumLists*ListDepth];
    logic [DW-1:0] rd_idx_reg [NumLists];
    logic [DW-1:0] wr_idx_reg [NumLists];
    logic [CW-1:0] cnt_reg    [NumLists];
    // Head key of each list, kept in registers so the scan needs no memory port.
    logic [31:0]   head_reg   [NumLists];

    logic [1:0]  cmd_reg;
    logic [2:0]  id_reg;
    logic [31:0] key_reg;
    logic [PayloadBits-1:0] pay_reg;

    logic [LW:0]   scan_reg;
    logic          scan_busy_reg;
    logic          best_v_reg;
    logic [LW-1:0] best_reg;
    logic [31:0]   best_key_reg;

    logic [31+PayloadBits:0] rdata_reg;
    logic [31+PayloadBits:0] nxt_data_reg;
    logic                    pending_reg;
    logic                    refresh_reg;
    logic [LW-1:0]           pend_list_reg;

    logic [2:0]    status_next;
    logic [2:0]    status_reg;

    logic          id_ok;
    logic [LW-1:0] id_l;
    logic [LW-1:0] scan_l;

    assign id_l   = id_reg[LW-1:0];
    assign id_ok  = ({29'd0, id_reg} < 32'(NumLists));
    assign scan_l = scan_reg[LW-1:0];

    assign stat_out.scan_busy = scan_busy_reg | pending_reg | refresh_reg;
    assign stat_out.cmd       = cmd_reg;
    assign stat_out.push_ok   = (key_reg != SentinelKey) && id_ok
                                && (cnt_reg[id_l] < CW'(ListDepth));
    assign stat_out.any_valid = best_v_reg;

    assign best_key = best_key_reg;
    assign r_status = status_reg;

    // Memory: one write and two read ports, read data registered.
    always_ff @(posedge aclk) begin
        if (cmd_in.push && stat_out.push_ok) begin
            mem[{id_l, wr_idx_reg[id_l]}] <= {key_reg, pay_reg};
        end
        rdata_reg    <= mem[{best_reg, rd_idx_reg[best_reg]}];
        nxt_data_reg <= mem[{pend_list_reg, rd_idx_reg[pend_list_reg]}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_busy_reg <= 1'b0;
            pending_reg   <= 1'b0;
            refresh_reg   <= 1'b0;
            best_v_reg    <= 1'b0;
            pend_list_reg <= '0;
            best_reg      <= '0;
            scan_reg      <= '0;
            for (int i = 0; i < NumLists; i++) begin
                rd_idx_reg[i] <= '0;
                wr_idx_reg[i] <= '0;
                cnt_reg[i]    <= '0;
            end
        end else begin
            if (cmd_in.load) begin
                cmd_reg <= s_cmd;
                id_reg  <= s_list_id;
                key_reg <= s_item_key;
                pay_reg <= s_item_payload[PayloadBits-1:0];
            end
            if (cmd_in.clear) begin
                for (int i = 0; i < NumLists; i++) begin
                    rd_idx_reg[i] <= '0;
                    wr_idx_reg[i] <= '0;
                    cnt_reg[i]    <= '0;
                end
            end
            if (cmd_in.push && stat_out.push_ok) begin
                wr_idx_reg[id_l] <= (wr_idx_reg[id_l] == DW'(ListDepth - 1)) ? '0
                                    : wr_idx_reg[id_l] + 1'b1;
                cnt_reg[id_l] <= cnt_reg[id_l] + 1'b1;
                if (cnt_reg[id_l] == '0) begin
                    head_reg[id_l] <= key_reg;
                end
            end
            if (cmd_in.pop) begin
                rd_idx_reg[best_reg] <= (rd_idx_reg[best_reg] == DW'(ListDepth - 1)) ? '0
                                        : rd_idx_reg[best_reg] + 1'b1;
                cnt_reg[best_reg] <= cnt_reg[best_reg] - 1'b1;
                pend_list_reg     <= best_reg;
                pending_reg       <= (cnt_reg[best_reg] > CW'(1));
            end
            // Head refresh of the popped list: the memory is read at the new
            // head in the cycle after the pop, and the registered read data is
            // then written into the cache.
            if (pending_reg && !cmd_in.pop) begin
                pending_reg <= 1'b0;
                refresh_reg <= 1'b1;
            end
            if (refresh_reg) begin
                refresh_reg <= 1'b0;
                head_reg[pend_list_reg] <= nxt_data_reg[31+PayloadBits:PayloadBits];
            end
            // Serial scan: one list per cycle while no head refresh is pending, ties go to the later list.
            if (cmd_in.scan_go) begin
                scan_busy_reg <= 1'b1;
                scan_reg      <= '0;
                best_v_reg    <= 1'b0;
            end else if (scan_busy_reg && !pending_reg && !refresh_reg) begin
                if (cnt_reg[scan_l] != '0 &&
                    (!best_v_reg || head_reg[scan_l] <= best_key_reg)) begin
                    best_v_reg   <= 1'b1;
                    best_reg     <= scan_l;
                    best_key_reg <= head_reg[scan_l];
                end
                if (scan_reg == (LW+1)'(NumLists - 1)) begin
                    scan_busy_reg <= 1'b0;
                end
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    // Result fields: pop data on a pop, sentinel values on finish; the controller fills status and next_key.
    always_ff @(posedge aclk) begin
        if (cmd_in.pop) begin
            r_popped_key     <= rdata_reg[31+PayloadBits:PayloadBits];
            r_popped_payload <= 32'(rdata_reg[PayloadBits-1:0]);
            r_source_list    <= 3'(best_reg);
        end else if (cmd_in.finish) begin
            r_popped_key     <= SentinelKey;
            r_popped_payload <= '0;
            r_source_list    <= '0;
        end
    end

    // Push status is judged before the push changes the list count.
    always_comb begin
        status_next = ST_PUSHED;
        if (cmd_reg == CMD_PUSH) begin
            if (key_reg == SentinelKey) status_next = ST_RESERVED;
            else if (!stat_out.push_ok) status_next = ST_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_in.scan_go) begin
            status_reg <= status_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/kwm_ctrl.sv
// ---------------------------------------------------------------------------
// kwm_ctrl
// Command sequencer and output register of the k-way merge.
// ---------------------------------------------------------------------------
`default_nettype none
module kwm_ctrl import kwm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output kwm_cmd_t         cmd_out,
    input  wire kwm_stat_t   stat_in,
    input  wire logic [2:0]  r_status,
    input  wire logic [31:0] r_popped_key,
    input  wire logic [31:0] r_popped_payload,
    input  wire logic [2:0]  r_source_list,
    input  wire logic [31:0] best_key,
    output logic [2:0]       m_status,
    output logic [31:0]      m_popped_key,
    output logic [31:0]      m_popped_payload,
    output logic [2:0]       m_source_list,
    output logic [31:0]      m_next_key
);
    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_POPSCAN, S_POPRD, S_POPDO, S_SCAN, S_DONE
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   pop_flag_reg;
    logic   empty_reg;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd_out = '0;
        cmd_out.load    = s_valid && s_ready;
        case (state_reg)
            S_EXEC: begin
                cmd_out.push    = (stat_in.cmd == CMD_PUSH);
                cmd_out.clear   = (stat_in.cmd[1] == 1'b1);
                cmd_out.scan_go = 1'b1;
            end
            S_POPDO: begin
                cmd_out.pop     = stat_in.any_valid;
                cmd_out.scan_go = 1'b1;
            end
            S_DONE:  cmd_out.finish = !pop_flag_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            pop_flag_reg <= 1'b0;
            empty_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_valid && s_ready) state_reg <= S_EXEC;
                S_EXEC: state_reg <= (stat_in.cmd == CMD_POP) ? S_POPSCAN : S_SCAN;
                S_POPSCAN: if (!stat_in.scan_busy) state_reg <= S_POPRD;
                S_POPRD: state_reg <= S_POPDO;
                S_POPDO: begin
                    pop_flag_reg <= stat_in.any_valid;
                    empty_reg    <= !stat_in.any_valid;
                    state_reg    <= S_SCAN;
                end
                S_SCAN: if (!stat_in.scan_busy) state_reg <= S_DONE;
                S_DONE: begin
                    m_status <= pop_flag_reg ? ST_POPPED
                              : (empty_reg ? ST_EMPTY : r_status);
                    if (!pop_flag_reg) begin
                        m_popped_key     <= SentinelKey;
                        m_popped_payload <= '0;
                        m_source_list    <= '0;
                    end else begin
                        m_popped_key     <= r_popped_key;
                        m_popped_payload <= r_popped_payload;
                        m_source_list    <= r_source_list;
                    end
                    m_next_key   <= stat_in.any_valid ? best_key : SentinelKey;
                    m_valid_reg  <= 1'b1;
                    pop_flag_reg <= 1'b0;
                    empty_reg    <= 1'b0;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// K-way merge testbench
// Drives push, pop and clear items into the merge block and checks every
// result against a behavioral model of the eight sorted lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import kwm_pkg::*;

class merge_scoreboard;
    // Behavioral copy of the lists, held as SystemVerilog queues.
    logic [31:0] keys [NumLists][$];
    logic [31:0] pays [NumLists][$];
    logic [2:0]  want_status [$];
    logic [31:0] want_pkey [$];
    logic [31:0] want_ppay [$];
    logic [2:0]  want_src [$];
    logic [31:0] want_next [$];
    int errors;

    function int winner();
        int best;
        best = -1;
        for (int l = 0; l < NumLists; l++) begin
            if (keys[l].size() != 0) begin
                if (best < 0 || keys[l][0] <= keys[best][0]) best = l;
            end
        end
        return best;
    endfunction

    function int count_of(int l);
        return keys[l].size();
    endfunction

    function int pending();
        return want_status.size();
    endfunction

    // Note an accepted input item and queue the result it causes.
    function void note_item(logic [1:0] cmd, logic [2:0] id, logic [31:0] key,
                            logic [31:0] pay);
        logic [2:0]  st;
        logic [31:0] pk, pp;
        logic [2:0]  src;
        int w;
        st = ST_PUSHED;
        pk = SentinelKey;
        pp = 0;
        src = 0;
        if (cmd == CMD_PUSH) begin
            if (key == SentinelKey) st = ST_RESERVED;
            else if (id >= NumLists || keys[id].size() >= ListDepth) st = ST_FULL;
            else begin
                keys[id].push_back(key);
                pays[id].push_back(pay);
            end
        end else if (cmd == CMD_POP) begin
            w = winner();
            if (w < 0) st = ST_EMPTY;
            else begin
                pk = keys[w].pop_front();
                pp = pays[w].pop_front();
                src = w[2:0];
                st = ST_POPPED;
            end
        end else begin
            for (int l = 0; l < NumLists; l++) begin
                keys[l].delete();
                pays[l].delete();
            end
        end
        w = winner();
        want_status.push_back(st);
        want_pkey.push_back(pk);
        want_ppay.push_back(pp);
        want_src.push_back(src);
        want_next.push_back(w < 0 ? SentinelKey : keys[w][0]);
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] pk, logic [31:0] pp,
                               logic [2:0] src, logic [31:0] nk);
        logic [2:0]  es, esrc;
        logic [31:0] epk, epp, enk;
        if (want_status.size() == 0) begin
            $display("%0t: unexpected result, status %0d", $time, st);
            errors++;
            return;
        end
        es = want_status.pop_front();
        epk = want_pkey.pop_front();
        epp = want_ppay.pop_front();
        esrc = want_src.pop_front();
        enk = want_next.pop_front();
        if (st !== es) begin
            $display("%0t: status expected %0d actual %0d", $time, es, st);
            errors++;
        end
        if (pk !== epk) begin
            $display("%0t: popped_key expected %h actual %h", $time, epk, pk);
            errors++;
        end
        if (pp !== epp) begin
            $display("%0t: popped_payload expected %h actual %h", $time, epp, pp);
            errors++;
        end
        if (src !== esrc) begin
            $display("%0t: source_list expected %0d actual %0d", $time, esrc, src);
            errors++;
        end
        if (nk !== enk) begin
            $display("%0t: next_key expected %h actual %h", $time, enk, nk);
            errors++;
        end
    endfunction
endclass

module testbench;
    // Command code three, which the block treats as a clear.
    localparam logic [1:0] CMD_CLEAR_ALT = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = CMD_PUSH;
    logic [2:0]  s_list_id = '0;
    logic [31:0] s_item_key = '0;
    logic [31:0] s_item_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_popped_key;
    logic [31:0] m_popped_payload;
    logic [2:0]  m_source_list;
    logic [31:0] m_next_key;

    // Percent chance per cycle that the sender idles and the receiver stalls.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // When set, the receiver refuses every result for a long stretch.
    bit hold_off = 1'b0;

    merge_scoreboard board;

    k_way_sorted_list_merge dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_list_id(s_list_id), .s_item_key(s_item_key),
        .s_item_payload(s_item_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_popped_key(m_popped_key), .m_popped_payload(m_popped_payload),
        .m_source_list(m_source_list), .m_next_key(m_next_key)
    );

    always #6 aclk = ~aclk;

    // Monitor: every handshake is sampled at the rising edge. Inputs are noted
    // into the model in acceptance order, and results are checked against it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_item(s_cmd, s_list_id, s_item_key, s_item_payload);
            if (m_valid && m_ready)
                board.check_result(m_status, m_popped_key, m_popped_payload,
                                   m_source_list, m_next_key);
        end
    end

    // Receiver: ready changes only at the falling edge. A hold-off keeps it low.
    always @(negedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one item and wait until it is accepted. Random idle cycles go
    // before valid is raised, never while it is high, so valid stays steady.
    // Valid is dropped only when an idle cycle follows or the stimulus ends.
    task automatic send_item(logic [1:0] cmd, logic [2:0] id, logic [31:0] key,
                             logic [31:0] pay);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_list_id <= id;
        s_item_key <= key;
        s_item_payload <= pay;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Keys drawn mostly from a narrow range so that ties and near-ties between
    // lists are common, with full-width and extreme values mixed in.
    function automatic logic [31:0] rand_key();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hffff_fffe;
            2, 3: return $urandom;
            default: return $urandom_range(40);
        endcase
    endfunction

    // One random item. The balance of pushes and pops drifts with the phase,
    // so the lists both fill up and drain empty over the run.
    task automatic send_random(int push_pct);
        int r;
        logic [2:0] id;
        r = $urandom_range(99);
        id = 3'($urandom_range(NumLists - 1));
        if (r < push_pct) begin
            if ($urandom_range(49) == 0) send_item(CMD_PUSH, id, SentinelKey, $urandom);
            else send_item(CMD_PUSH, id, rand_key(), $urandom);
        end else if (r < 98) begin
            send_item(CMD_POP, id, $urandom, $urandom);
        end else begin
            // Command code three behaves as a clear.
            send_item(($urandom_range(1) != 0) ? CMD_CLEAR : CMD_CLEAR_ALT, id,
                      $urandom, $urandom);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (2 * NumLists + 10) @(negedge aclk);
    endtask

    initial begin
        board = new();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. Pop on empty, extremes of keys and payloads, ties
        // between lists resolved toward the higher list, the reserved key,
        // then a clear.
        send_item(CMD_POP, 3'd0, 32'h0, 32'h0);
        send_item(CMD_PUSH, 3'd0, 32'h0, 32'hffff_ffff);
        send_item(CMD_PUSH, 3'd7, 32'h0, 32'h0);
        send_item(CMD_PUSH, 3'd3, 32'hffff_fffe, 32'ha5a5_5a5a);
        send_item(CMD_PUSH, 3'd5, SentinelKey, 32'h1234_5678);
        send_item(CMD_PUSH, 3'd2, 32'h8000_0000, 32'h5a5a_a5a5);
        send_item(CMD_PUSH, 3'd1, 32'h7fff_ffff, 32'h0000_0001);
        send_item(CMD_PUSH, 3'd4, 32'h7fff_ffff, 32'h8000_0000);
        send_item(CMD_PUSH, 3'd6, 32'h5, 32'h6);
        send_item(CMD_PUSH, 3'd6, 32'h1, 32'h7);
        for (int i = 0; i < 8; i++) send_item(CMD_POP, 3'd7, 32'hffff_ffff, 32'hffff_ffff);
        send_item(CMD_PUSH, 3'd2, 32'h9, 32'h9);
        send_item(CMD_CLEAR, 3'd0, 32'h0, 32'h0);
        send_item(CMD_POP, 3'd0, 32'h0, 32'h0);
        send_item(CMD_CLEAR_ALT, 3'd0, 32'h0, 32'h0);

        // Fill one list to its depth and push once more to see it dropped.
        for (int i = 0; i < ListDepth; i++) send_item(CMD_PUSH, 3'd4, i, ~i);
        send_item(CMD_PUSH, 3'd4, 32'h1, 32'h1);
        send_item(CMD_POP, 3'd0, 32'h0, 32'h0);
        send_item(CMD_CLEAR, 3'd0, 32'h0, 32'h0);

        // Random part in idling phases: none, sender, receiver, both.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1) ? 47 : (phase == 3) ? 22 : 0;
            recv_stall_pct = (phase == 2) ? 47 : (phase == 3) ? 22 : 0;
            for (int i = 0; i < 90; i++)
                send_random((i % 45) < 22 ? 70 : 35);
        end

        // Long receiver hold-off while the sender keeps offering items.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++) send_random(60);
        join

        wait_drained();
        if (board.errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/kwm_pkg.sv
rtl/core/kwm_datapath.sv
rtl/core/kwm_ctrl.sv
rtl/core/k_way_sorted_list_merge.sv
bench/testbench.sv
